>>> sv/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_FG   = 2'd0;
  localparam logic [1:0] REG_BG   = 2'd1;
  localparam logic [1:0] REG_COLS = 2'd2;
  localparam logic [1:0] REG_ROWS = 2'd3;

  // Control characters and cell values.
  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_SPACE     = 8'd32;
  localparam logic [15:0] RESET_CELL   = 16'h0F00;

  // Reset values of the configuration registers.
  localparam logic [3:0] FG_RESET   = 4'd15;
  localparam logic [3:0] BG_RESET   = 4'd0;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd25;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_DONE
  } state_t;

  // Configuration register file as seen by the sequencer.
  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] cols;
    logic [6:0] rows;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_line;
    logic        scrolled;
  } res_t;

endpackage

>>> sv/tcw_in_if.sv
`timescale 1ns / 1ps

interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_code;
  logic [6:0] read_col;
  logic [5:0] read_row;

  modport source (output valid, output op, output char_code, output read_col,
                  output read_row, input ready);
  modport sink (input valid, input op, input char_code, input read_col,
                input read_row, output ready);
endinterface

>>> sv/tcw_out_if.sv
`timescale 1ns / 1ps

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_data;
  logic [6:0]  cursor_column;
  logic [5:0]  cursor_line;
  logic        scrolled;

  modport source (output valid, output cell_data, output cursor_column,
                  output cursor_line, output scrolled, input ready);
  modport sink (input valid, input cell_data, input cursor_column,
                input cursor_line, input scrolled, output ready);
endinterface

>>> sv/tcw_cfg_if.sv
`timescale 1ns / 1ps

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

>>> sv/text_console_cell_writer_unit.sv
`timescale 1ns / 1ps

// Text console cell writer. A grid of 16-bit cells (attribute byte above
// character byte) sits in one on-chip memory with one write and one registered
// read port, and a small sequencer drives every access. After reset the block
// first runs a clearing pass that writes 0x0F00 to every cell, during which no
// input transaction is taken; configuration writes are taken at any time and
// must only be issued while the block is idle. A put that does not scroll, a
// read or an unused opcode passes through the accepting idle state and one
// execute state; its result is loaded into the output register there, or later
// from the done state if the register is still full. A clear writes every
// active cell in turn, and a put that scrolls copies every row up by one,
// reading and writing each cell through the single memory in turn, and then
// fills the last row; for both the result is presented in the same cycle as
// the block is ready again. One transaction is in work at a time; a finished
// result waits in the output register while the next transaction is
// accepted.
module text_console_cell_writer_unit #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tcw_in_if.sink      in_if,
  tcw_out_if.source   out_if,
  tcw_cfg_if.sink     cfg_if
);
  import tcw_pkg::*;

  localparam int AW = $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS);

  cfg_t          cfg_r;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  // Configuration registers.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg   <= FG_RESET;
      cfg_r.bg   <= BG_RESET;
      cfg_r.cols <= COLS_RESET;
      cfg_r.rows <= ROWS_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.addr)
        REG_FG:   cfg_r.fg   <= cfg_if.data[3:0];
        REG_BG:   cfg_r.bg   <= cfg_if.data[3:0];
        REG_COLS: cfg_r.cols <= cfg_if.data;
        REG_ROWS: cfg_r.rows <= cfg_if.data[6:0];
        default:  cfg_r      <= cfg_r;
      endcase
    end
  end

  // Sequencer with cursor and output register.
  tcw_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_op        (in_if.op),
    .in_char_code (in_if.char_code),
    .in_read_col  (in_if.read_col),
    .in_read_row  (in_if.read_row),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_res      (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Cell store.
  tcw_cell_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result fields.
  assign out_if.cell_data     = res.cell_data;
  assign out_if.cursor_column = res.cursor_column;
  assign out_if.cursor_line   = res.cursor_line;
  assign out_if.scrolled      = res.scrolled;

endmodule

>>> sv/tcw_cell_mem.sv
`timescale 1ns / 1ps

module tcw_cell_mem #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem_q [2**AW];
  logic [15:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_r <= mem_q[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  localparam int AW = $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tcw_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_char_code,
  input  logic [6:0]    in_read_col,
  input  logic [5:0]    in_read_row,
  output logic          out_valid,
  input  logic          out_ready,
  output tcw_pkg::res_t out_res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [15:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [15:0]   mem_rdata
);
  import tcw_pkg::*;

  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cursor_col_r, cursor_col_nxt;
  logic [RW-1:0] cursor_row_r, cursor_row_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [CW-1:0] walk_col_r, walk_col_nxt;
  logic [RW-1:0] walk_row_r, walk_row_nxt;
  logic [15:0]   fill_data_r, fill_data_nxt;
  logic [AW-1:0] init_addr_r, init_addr_nxt;
  logic [15:0]   pend_cell_r, pend_cell_nxt;
  logic          pend_scr_r, pend_scr_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  logic [CW-1:0] cols_c;
  logic [RW-1:0] rows_c;
  logic [7:0]    attr;
  logic          fin;
  logic          slot_free;
  logic          out_load;
  logic [31:0]   rcol_ext, rrow_ext, col_ext, row_ext;
  logic          rd_ok_in;

  logic [CW-1:0] col_a, put_col, put_wcol;
  logic [RW-1:0] row_a, put_row;
  logic          put_we, put_scroll;
  logic [15:0]   put_wdata;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    cell_addr = {row[RIW-1:0], col[CIW-1:0]};
  endfunction

  // Active size, clamped to the store.
  always_comb begin
    if (cfg.cols == 8'd0) begin
      cols_c = CW'(1);
    end else if (int'(cfg.cols) > MAX_COLUMNS) begin
      cols_c = CW'(MAX_COLUMNS);
    end else begin
      cols_c = CW'(cfg.cols);
    end
    if (cfg.rows == 7'd0) begin
      rows_c = RW'(1);
    end else if (int'(cfg.rows) > MAX_ROWS) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(cfg.rows);
    end
  end

  assign attr = {cfg.bg, cfg.fg};

  // Read address straight from the input so the data is back in the execute cycle.
  assign rcol_ext = 32'(in_read_col);
  assign rrow_ext = 32'(in_read_row);
  assign rd_ok_in = (int'(in_read_col) < MAX_COLUMNS) && (int'(in_read_row) < MAX_ROWS);

  // Cursor movement and cell write for a put. The cursor always lies inside the
  // store, so the written cell needs no range check.
  always_comb begin
    col_a     = cursor_col_r;
    row_a     = cursor_row_r;
    put_we    = 1'b0;
    put_wcol  = cursor_col_r;
    put_wdata = {attr, char_r};
    priority if (char_r == CH_NEWLINE) begin
      col_a = '0;
      row_a = cursor_row_r + RW'(1);
    end else if (char_r == CH_RETURN) begin
      col_a = '0;
    end else if (char_r == CH_BACKSPACE) begin
      if (cursor_col_r != '0) begin
        col_a     = cursor_col_r - CW'(1);
        put_we    = 1'b1;
        put_wcol  = cursor_col_r - CW'(1);
        put_wdata = {attr, CH_SPACE};
      end
    end else if (cursor_col_r < cols_c) begin
      put_we = 1'b1;
      col_a  = cursor_col_r + CW'(1);
    end
    if (col_a >= cols_c) begin
      put_col = '0;
      put_row = row_a + RW'(1);
    end else begin
      put_col = col_a;
      put_row = row_a;
    end
    put_scroll = (put_row >= rows_c);
  end

  assign slot_free = !out_valid_r || out_ready;

  // Sequencer: one memory access per cycle, walking the grid for scroll and clear.
  always_comb begin
    state_nxt      = state_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    op_nxt         = op_r;
    char_nxt       = char_r;
    rd_ok_nxt      = rd_ok_r;
    walk_col_nxt   = walk_col_r;
    walk_row_nxt   = walk_row_r;
    fill_data_nxt  = fill_data_r;
    init_addr_nxt  = init_addr_r;
    pend_cell_nxt  = pend_cell_r;
    pend_scr_nxt   = pend_scr_r;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr(walk_row_r, walk_col_r);
    mem_wdata      = fill_data_r;
    mem_raddr      = {rrow_ext[RIW-1:0], rcol_ext[CIW-1:0]};
    in_ready       = 1'b0;
    fin            = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        mem_we        = 1'b1;
        mem_waddr     = init_addr_r;
        mem_wdata     = RESET_CELL;
        init_addr_nxt = init_addr_r + AW'(1);
        if (&init_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_op;
          char_nxt  = in_char_code;
          rd_ok_nxt = rd_ok_in;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        pend_cell_nxt = '0;
        pend_scr_nxt  = 1'b0;
        unique case (op_r)
          OP_PUT: begin
            mem_we         = put_we;
            mem_waddr      = cell_addr(cursor_row_r, put_wcol);
            mem_wdata      = put_wdata;
            cursor_col_nxt = put_col;
            if (put_scroll) begin
              cursor_row_nxt = rows_c - RW'(1);
              pend_scr_nxt   = 1'b1;
              walk_col_nxt   = '0;
              walk_row_nxt   = '0;
              fill_data_nxt  = RESET_CELL;
              state_nxt      = (rows_c == RW'(1)) ? ST_FILL : ST_SCR_RD;
            end else begin
              cursor_row_nxt = put_row;
              fin            = 1'b1;
            end
          end
          OP_READ: begin
            pend_cell_nxt = rd_ok_r ? mem_rdata : '0;
            fin           = 1'b1;
          end
          OP_CLEAR: begin
            cursor_col_nxt = '0;
            cursor_row_nxt = '0;
            walk_col_nxt   = '0;
            walk_row_nxt   = '0;
            fill_data_nxt  = {attr, CH_SPACE};
            state_nxt      = ST_FILL;
          end
          OP_NONE: begin
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_SCR_RD: begin
        mem_raddr = cell_addr(walk_row_r + RW'(1), walk_col_r);
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        state_nxt = ST_SCR_RD;
        if (walk_col_r == cols_c - CW'(1)) begin
          walk_col_nxt = '0;
          walk_row_nxt = walk_row_r + RW'(1);
          if (walk_row_r + RW'(1) == rows_c - RW'(1)) begin
            state_nxt = ST_FILL;
          end
        end else begin
          walk_col_nxt = walk_col_r + CW'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (walk_col_r == cols_c - CW'(1)) begin
          walk_col_nxt = '0;
          if (walk_row_r == rows_c - RW'(1)) begin
            fin = 1'b1;
          end else begin
            walk_row_nxt = walk_row_r + RW'(1);
          end
        end else begin
          walk_col_nxt = walk_col_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = slot_free ? ST_IDLE : ST_DONE;
    end
  end

  // Output register: loads when an item finishes and the slot is free.
  assign col_ext = 32'(cursor_col_nxt);
  assign row_ext = 32'(cursor_row_nxt);

  always_comb begin
    out_load      = (fin || state_r == ST_DONE) && slot_free;
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
    out_res_nxt   = out_res_r;
    if (out_load) begin
      out_res_nxt.cell_data     = pend_cell_nxt;
      out_res_nxt.cursor_column = col_ext[6:0];
      out_res_nxt.cursor_line   = row_ext[5:0];
      out_res_nxt.scrolled      = pend_scr_nxt;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      init_addr_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      init_addr_r  <= init_addr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    char_r      <= char_nxt;
    rd_ok_r     <= rd_ok_nxt;
    walk_col_r  <= walk_col_nxt;
    walk_row_r  <= walk_row_nxt;
    fill_data_r <= fill_data_nxt;
    pend_cell_r <= pend_cell_nxt;
    pend_scr_r  <= pend_scr_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The clearing pass never reports a result.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !out_valid_r)
    else $error("result presented during clearing pass");

  // The store is only written while an item or the clearing pass is in work.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE && state_r != ST_DONE))
    else $error("cell store written while idle");

  // The cursor never leaves the store.
  a_cursor_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_col_r < CW'(MAX_COLUMNS)) && (cursor_row_r < RW'(MAX_ROWS)))
    else $error("cursor outside the cell store");

  // An accepted transaction is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EXEC))
    else $error("accepted transaction not executed");

endmodule
